FILE: hdl/frtc_pkg.sv
`timescale 1ns / 1ps

package frtc_pkg;

    // Action codes carried by an input beat.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Register byte offsets.
    localparam logic [2:0] OFS_ENABLE  = 3'd0;
    localparam logic [2:0] OFS_STATUS  = 3'd1;
    localparam logic [2:0] OFS_CNT_HI  = 3'd2;
    localparam logic [2:0] OFS_CNT_LO  = 3'd3;
    localparam logic [2:0] OFS_CMP_HI  = 3'd4;
    localparam logic [2:0] OFS_CMP_LO  = 3'd5;
    localparam logic [2:0] OFS_CLOCK   = 3'd6;
    localparam logic [2:0] OFS_CMP_CTL = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEVEL    = 2'd0;
    localparam logic [1:0] CFG_CMP_VEC  = 2'd1;
    localparam logic [1:0] CFG_OVF_VEC  = 2'd2;

    // Clock modes.
    localparam logic [1:0] MODE_DIV8   = 2'd0;
    localparam logic [1:0] MODE_DIV32  = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    // Register masks and fixed bits.
    localparam logic [7:0] MASK_READ_FLAGS = 8'h8F;
    localparam logic [7:0] MASK_FLAGS      = 8'h8E;
    localparam logic [7:0] MASK_CLOCK      = 8'h83;
    localparam logic [7:0] MASK_CMP_CTL    = 8'h13;
    localparam logic [7:0] FIXED_CMP_CTL   = 8'hE0;
    localparam logic [7:0] BIT_CLEAR_EN    = 8'h01;
    localparam logic [7:0] SEL_CMP_B       = 8'h10;

    // Reset values.
    localparam logic [15:0] RST_COMPARE = 16'hFFFF;
    localparam logic [7:0]  RST_ENABLE  = 8'h01;

    // Width of the prescale accumulator.
    localparam int PRESC_W = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] elapsed_cycles;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pending;
        logic [3:0] irq_priority;
        logic [6:0] irq_vector;
    } out_item_t;

    // Result of one counter advance from the step unit.
    typedef struct packed {
        logic [15:0] count;
        logic        ovf;
        logic        hit_a;
        logic        hit_b;
    } step_t;

    // Prescale period for a clock mode.
    function automatic logic [PRESC_W-1:0] period_of(input logic [1:0] mode);
        logic [PRESC_W-1:0] p;
        case (mode)
            MODE_DIV8:  p = PRESC_W'(8);
            MODE_DIV32: p = PRESC_W'(32);
            default:    p = PRESC_W'(128);
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/frtc_step.sv
`timescale 1ns / 1ps

module frtc_step (
    input  logic [15:0]     count,
    input  logic [15:0]     cmp_a,
    input  logic [15:0]     cmp_b,
    input  logic            clear_en,
    output frtc_pkg::step_t step
);
    import frtc_pkg::*;

    logic [15:0] inc;

    // One counter increment, then compare A (with optional clear), then compare B
    // against the value that remains.
    always_comb
    begin
        inc        = count + 16'd1;
        step.ovf   = (inc == 16'd0);
        step.hit_a = (inc == cmp_a);
        step.count = (step.hit_a && clear_en) ? 16'd0 : inc;
        step.hit_b = (step.count == cmp_b);
    end

endmodule

FILE: hdl/free_running_timer_compare_unit.sv
`timescale 1ns / 1ps

// Channel   Signals                                 Beat moves
// in        in_valid, in_ready, in_data             one read, write or tick
// out       out_valid, out_ready, out_data          one result per input beat
// cfg       cfg_valid, cfg_ready, cfg_index/data    one interrupt setting
//
// For a read, write or stopped tick, the sequencer goes from ST_IDLE to ST_DONE, and
// out_valid rises once ST_DONE loads the output register. A running tick first goes
// through ST_TICK, one advance per prescale period elapsed (up to 32, at divide by 8),
// since all counter advances go through the single step unit, and then to ST_DONE.
// in_ready stays low until the result enters the output register, which waits
// for out_ready while it still holds a beat.
// The next input beat is taken while a result still waits in the output register.
// Reset is asynchronous and active low; it restores all timer registers.
// cfg_ready is always high.

module free_running_timer_compare_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  frtc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output frtc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import frtc_pkg::*;

    state_t state_reg, state_next;
    logic [15:0] counter_reg, counter_next;
    logic [15:0] cmp_a_reg, cmp_a_next;
    logic [15:0] cmp_b_reg, cmp_b_next;
    logic [7:0]  ien_reg, ien_next;
    logic [7:0]  stat_reg, stat_next;
    logic [7:0]  clk_ctrl_reg, clk_ctrl_next;
    logic [7:0]  cmp_ctrl_reg, cmp_ctrl_next;
    logic [PRESC_W-1:0] presc_reg, presc_next;
    logic [7:0]  temp_reg, temp_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  rd_reg, rd_next;
    logic [3:0]  level_reg;
    logic [6:0]  cvec_reg;
    logic [6:0]  ovec_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg, result;
    logic        out_load;
    logic [PRESC_W-1:0] period;
    logic [15:0] sel_cmp;
    logic        oci;
    step_t       step;

    // Shared advance unit.
    frtc_step u_step (
        .count    (counter_reg),
        .cmp_a    (cmp_a_reg),
        .cmp_b    (cmp_b_reg),
        .clear_en (stat_reg[0]),
        .step     (step)
    );

    assign period    = period_of(clk_ctrl_reg[1:0]);
    assign sel_cmp   = ((cmp_ctrl_reg & SEL_CMP_B) != 8'd0) ? cmp_b_reg : cmp_a_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and register updates.
    always_comb
    begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        cmp_a_next    = cmp_a_reg;
        cmp_b_next    = cmp_b_reg;
        ien_next      = ien_reg;
        stat_next     = stat_reg;
        clk_ctrl_next = clk_ctrl_reg;
        cmp_ctrl_next = cmp_ctrl_reg;
        presc_next    = presc_reg;
        temp_next     = temp_reg;
        seen_next     = seen_reg;
        rd_next       = rd_reg;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_next    = 8'd0;
                    state_next = ST_DONE;
                    case (in_data.action)
                        ACT_READ:
                        begin
                            case (in_data.reg_offset)
                                OFS_ENABLE: rd_next = ien_reg & MASK_READ_FLAGS;
                                OFS_STATUS:
                                begin
                                    rd_next   = stat_reg & MASK_READ_FLAGS;
                                    seen_next = seen_reg | (stat_reg & MASK_FLAGS);
                                end
                                OFS_CNT_HI:
                                begin
                                    rd_next   = counter_reg[15:8];
                                    temp_next = counter_reg[7:0];
                                end
                                OFS_CNT_LO: rd_next = temp_reg;
                                OFS_CMP_HI: rd_next = sel_cmp[15:8];
                                OFS_CMP_LO: rd_next = sel_cmp[7:0];
                                OFS_CLOCK:  rd_next = clk_ctrl_reg & MASK_CLOCK;
                                default:    rd_next = FIXED_CMP_CTL | (cmp_ctrl_reg & MASK_CMP_CTL);
                            endcase
                        end
                        ACT_WRITE:
                        begin
                            case (in_data.reg_offset)
                                OFS_ENABLE:
                                    ien_next = (in_data.write_data & MASK_FLAGS) | RST_ENABLE;
                                OFS_STATUS:
                                begin
                                    // A flag clears only if it was seen set and 0 is written.
                                    stat_next = (stat_reg & (in_data.write_data | ~seen_reg)
                                                 & MASK_FLAGS)
                                                | (in_data.write_data & BIT_CLEAR_EN);
                                    seen_next = seen_reg & in_data.write_data;
                                end
                                OFS_CNT_HI, OFS_CMP_HI: temp_next = in_data.write_data;
                                OFS_CNT_LO: counter_next = {temp_reg, in_data.write_data};
                                OFS_CMP_LO:
                                begin
                                    if ((cmp_ctrl_reg & SEL_CMP_B) != 8'd0)
                                    begin
                                        cmp_b_next = {temp_reg, in_data.write_data};
                                    end
                                    else
                                    begin
                                        cmp_a_next = {temp_reg, in_data.write_data};
                                    end
                                end
                                OFS_CLOCK:
                                begin
                                    clk_ctrl_next = in_data.write_data & MASK_CLOCK;
                                    presc_next    = '0;
                                end
                                default:
                                    cmp_ctrl_next = FIXED_CMP_CTL
                                                    | (in_data.write_data & MASK_CMP_CTL);
                            endcase
                        end
                        ACT_TICK:
                        begin
                            if (clk_ctrl_reg[1:0] != MODE_STOP)
                            begin
                                presc_next = presc_reg + {1'b0, in_data.elapsed_cycles};
                                state_next = ST_TICK;
                            end
                        end
                        default:
                        begin
                            rd_next = 8'd0;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                // One prescale period per cycle through the step unit.
                if (presc_reg >= period)
                begin
                    presc_next   = presc_reg - period;
                    counter_next = step.count;
                    stat_next    = stat_reg | {4'd0, step.hit_a, step.hit_b, step.ovf, 1'b0};
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Interrupt request: compare outranks overflow, zero level or zero vector requests nothing.
    always_comb
    begin
        oci                 = (stat_reg[3] & ien_reg[3]) | (stat_reg[2] & ien_reg[2]);
        result.read_data    = rd_reg;
        result.irq_priority = 4'd0;
        result.irq_vector   = 7'd0;
        if (level_reg != 4'd0)
        begin
            if (oci && (cvec_reg != 7'd0))
            begin
                result.irq_priority = level_reg;
                result.irq_vector   = cvec_reg;
            end
            else if (stat_reg[1] && ien_reg[1] && (ovec_reg != 7'd0))
            begin
                result.irq_priority = level_reg;
                result.irq_vector   = ovec_reg;
            end
        end
        result.irq_pending = (result.irq_vector != 7'd0);
    end

    // State and timer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            counter_reg  <= 16'd0;
            cmp_a_reg    <= RST_COMPARE;
            cmp_b_reg    <= RST_COMPARE;
            ien_reg      <= RST_ENABLE;
            stat_reg     <= 8'd0;
            clk_ctrl_reg <= 8'd0;
            cmp_ctrl_reg <= FIXED_CMP_CTL;
            presc_reg    <= '0;
            temp_reg     <= 8'd0;
            seen_reg     <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            counter_reg  <= counter_next;
            cmp_a_reg    <= cmp_a_next;
            cmp_b_reg    <= cmp_b_next;
            ien_reg      <= ien_next;
            stat_reg     <= stat_next;
            clk_ctrl_reg <= clk_ctrl_next;
            cmp_ctrl_reg <= cmp_ctrl_next;
            presc_reg    <= presc_next;
            temp_reg     <= temp_next;
            seen_reg     <= seen_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 4'd0;
            cvec_reg  <= 7'd0;
            ovec_reg  <= 7'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL:   level_reg <= cfg_data[3:0];
                CFG_CMP_VEC: cvec_reg  <= cfg_data[6:0];
                CFG_OVF_VEC: ovec_reg  <= cfg_data[6:0];
                default:     level_reg <= level_reg;
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: hdl/frtc_checker.sv
`timescale 1ns / 1ps

module frtc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input frtc_pkg::out_item_t out_data
);
    import frtc_pkg::*;

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // One item at a time: no input beat right after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // Pending flag follows the vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.irq_pending == (out_data.irq_vector != 7'd0))
        else $error("pending flag disagrees with vector");

    // A pending interrupt has a nonzero level, none has level zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.irq_pending == (out_data.irq_priority != 4'd0))
        else $error("priority disagrees with pending flag");

endmodule

bind free_running_timer_compare_unit frtc_checker u_frtc_checker (.*);
